[design/ggs_pkg.sv]
// Shared constants, codes and controller/datapath interface types
// for the gated gradient sharpening unit. No dependencies.
package ggs_pkg;

	localparam int PIX_W          = 8;
	localparam int SIZE_W         = 11;
	localparam int THR_W          = 8;
	localparam int CFG_IDX_W      = 2;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [SIZE_W-1:0] RST_WIDTH     = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] RST_HEIGHT    = SIZE_W'(480);
	localparam logic [THR_W-1:0]  RST_THRESHOLD = THR_W'(30);

	localparam logic [PIX_W:0]   BOOST   = (PIX_W+1)'(100);
	localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(255);

	// Root of a sum of two squared 9-bit differences: 18-bit radicand,
	// 9-bit root, one root bit per step.
	localparam int SUM_W      = 18;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int CNT_W      = $clog2(ROOT_STEPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH     = 2'd0,
		CFG_HEIGHT    = 2'd1,
		CFG_THRESHOLD = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic capture;
		logic read;
		logic square;
		logic root_step;
		logic load_out;
	} ggs_cmd_t;

	typedef struct packed {
		logic root_done;
	} ggs_stat_t;

endpackage

[design/ggs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ggs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/ggs_ctrl.sv]
// Sequencer for one pixel: accept, line store read, square, root steps,
// result hand-off. Uses ggs_pkg.
module ggs_ctrl
	import ggs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output ggs_cmd_t  cmd,
	input  ggs_stat_t stat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_ROOT,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.read      = (state_q == ST_READ);
		cmd.square    = (state_q == ST_SQUARE);
		cmd.root_step = (state_q == ST_ROOT);
		cmd.load_out  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ:   state_q <= ST_SQUARE;
				ST_SQUARE: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (stat.root_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/ggs_dp.sv]
// Datapath: configuration registers, raster position, line store,
// squared differences, bit-serial square root and result register.
// Uses ggs_pkg and ggs_ram.
module ggs_dp
	import ggs_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic [PIX_W-1:0]     pixel_in,
	input  logic                 frame_start,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 row_end,
	output logic                 frame_end,
	input  ggs_cmd_t             cmd,
	output ggs_stat_t            stat
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int EWW = (SIZE_W > CW + 1) ? SIZE_W : CW + 1;
	localparam int EWH = (SIZE_W > RW + 1) ? SIZE_W : RW + 1;

	logic [SIZE_W-1:0] width_q, height_q;
	logic [THR_W-1:0]  thresh_q;

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [PIX_W-1:0] left_q;

	logic [PIX_W-1:0] pix_s1, left_s1;
	logic [CW-1:0]    col_s1;
	logic             lastc_s1, lastr_s1, inner_s1;

	logic [SUM_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [PIX_W-1:0] up_pix;

	logic [EWW-1:0] w_ext;
	logic [EWH-1:0] h_ext;
	logic [CW-1:0]  w_m1;
	logic [RW-1:0]  h_m1;
	logic [CW-1:0]  c_cur;
	logic [RW-1:0]  r_cur;
	logic           lastc, lastr;

	// Clamp the sizes: zero acts as one, oversize acts as the maximum.
	always_comb begin
		w_ext = EWW'(width_q);
		h_ext = EWH'(height_q);
		if (width_q == '0) begin
			w_m1 = '0;
		end else if (w_ext > EWW'(MAX_WIDTH)) begin
			w_m1 = CW'(MAX_WIDTH - 1);
		end else begin
			w_m1 = CW'(w_ext - EWW'(1));
		end
		if (height_q == '0) begin
			h_m1 = '0;
		end else if (h_ext > EWH'(MAX_HEIGHT)) begin
			h_m1 = RW'(MAX_HEIGHT - 1);
		end else begin
			h_m1 = RW'(h_ext - EWH'(1));
		end
		c_cur = frame_start ? '0 : col_q;
		r_cur = frame_start ? '0 : row_q;
		lastc = (c_cur >= w_m1);
		lastr = (r_cur >= h_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			thresh_q <= RST_THRESHOLD;
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIDTH:     width_q  <= cfg_data;
					CFG_HEIGHT:    height_q <= cfg_data;
					CFG_THRESHOLD: thresh_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.capture) begin
				left_q <= pixel_in;
				if (lastc) begin
					col_q <= '0;
					row_q <= lastr ? '0 : r_cur + RW'(1);
				end else begin
					col_q <= c_cur + CW'(1);
					row_q <= r_cur;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_s1   <= pixel_in;
			left_s1  <= left_q;
			col_s1   <= c_cur;
			lastc_s1 <= lastc;
			lastr_s1 <= lastr;
			inner_s1 <= (r_cur != '0) && !lastr && (c_cur != '0) && !lastc;
		end
	end

	// Read the upper neighbor first, overwrite it with this pixel in the next cycle.
	ggs_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (cmd.square),
		.waddr(col_s1),
		.wdata(pix_s1),
		.re   (cmd.read),
		.raddr(col_s1),
		.rdata(up_pix)
	);

	logic signed [PIX_W:0]   d_left, d_up;
	logic signed [SUM_W-1:0] sq_left, sq_up;
	logic [REM_W-1:0]        rem_in, trial;

	always_comb begin
		d_left  = $signed({1'b0, pix_s1}) - $signed({1'b0, left_s1});
		d_up    = $signed({1'b0, pix_s1}) - $signed({1'b0, up_pix});
		sq_left = d_left * d_left;
		sq_up   = d_up * d_up;
		rem_in  = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
		trial   = REM_W'({root_q, 2'b01});
	end

	// Digit-by-digit root: bring down two radicand bits per step.
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			rad_q  <= $unsigned(sq_left) + $unsigned(sq_up);
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[SUM_W-3:0], 2'b00};
			cnt_q <= cnt_q + CNT_W'(1);
			if (rem_in >= trial) begin
				rem_q  <= rem_in - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_in;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign stat.root_done = (cnt_q == CNT_W'(ROOT_STEPS - 1));

	logic [PIX_W-1:0] grad, result;
	logic [PIX_W:0]   boosted;

	always_comb begin
		grad    = (root_q > ROOT_W'(PIX_MAX)) ? PIX_MAX : root_q[PIX_W-1:0];
		boosted = {1'b0, grad} + BOOST;
		if (!inner_s1) begin
			result = '0;
		end else if (grad >= thresh_q) begin
			result = boosted[PIX_W] ? PIX_MAX : boosted[PIX_W-1:0];
		end else begin
			result = pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pixel_out <= result;
			row_end   <= lastc_s1;
			frame_end <= lastc_s1 && lastr_s1;
		end
	end

endmodule

[design/gated_gradient_sharpen_unit.sv]
// Top level of the gated gradient sharpening unit: sequencer plus datapath.
// Uses ggs_pkg, ggs_ctrl and ggs_dp (which holds the ggs_ram line store).
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, pixel_in, frame_start | to block
//  out     | out_valid, out_stall, pixel_out, row_end, | from block
//          | frame_end                                 |
//  cfg     | cfg_we, cfg_index, cfg_data               | to block
//
// From acceptance to a valid result, one pixel passes through a line store
// read, a squaring step, 9 square root steps (one bit each) and the hand-off.
// No new pixel is accepted while one is still in flight.
// A new pixel is taken as soon as the previous result sits in the output
// register; a stalled output holds the sequencer in its last state.
// Reset loads 640 x 480 and threshold 30 and puts the position at row 0,
// column 0; the line store has no reset; unwritten words feed only border pixels.
module gated_gradient_sharpen_unit
	import ggs_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     pixel_in,
	input  logic                 frame_start,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 row_end,
	output logic                 frame_end
);

	ggs_cmd_t  cmd;
	ggs_stat_t stat;

	ggs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	ggs_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_in   (pixel_in),
		.frame_start(frame_start),
		.pixel_out  (pixel_out),
		.row_end    (row_end),
		.frame_end  (frame_end),
		.cmd        (cmd),
		.stat       (stat)
	);

	// An accepted pixel blocks the input in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not blocked after accepting an item");

	// A result appears only while the sequencer is busy with an item.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in flight");

	// The last pixel of a frame is always the last of its row.
	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!frame_end || row_end))
		else $error("frame end without row end");

endmodule
